### design/msm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_pkg
// Types and constants shared by the media stream statistics monitor modules.
// ----------------------------------------------------------------------------
package msm_pkg;

   localparam int REQ_DATA_W = 88;
   localparam int REQ_USER_W = 5;
   localparam int RSP_DATA_W = 336;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam int DIVIDEND_W = 53;

   localparam logic [1:0] FUNC_MEDIA  = 2'd0;
   localparam logic [1:0] FUNC_START  = 2'd1;
   localparam logic [1:0] FUNC_STOP   = 2'd2;
   localparam logic [1:0] MEDIA_VIDEO = 2'd0;
   localparam logic [1:0] MEDIA_AUDIO = 2'd1;

   localparam logic [CSR_ADDR_W-1:0] CSR_GAP_THRESHOLD  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_BITRATE_WINDOW = 1'b1;

   localparam logic [31:0] GAP_THRESHOLD_RST  = 32'd1000;
   localparam logic [31:0] BITRATE_WINDOW_RST = 32'd1000;
   localparam logic [31:0] WRAP_HALF          = 32'h8000_0000;
   localparam logic [31:0] WRAP_LOW           = 32'h7FFF_FFFF;
   localparam logic [31:0] COUNT_MAX          = 32'hFFFF_FFFF;
   localparam logic [47:0] BYTES_MAX          = 48'hFFFF_FFFF_FFFF;
   localparam logic [39:0] WINDOW_BYTES_MAX   = 40'hFF_FFFF_FFFF;

   typedef enum logic [1:0] {
      OP_MEDIA,
      OP_START,
      OP_STOP,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      KIND_VIDEO,
      KIND_AUDIO,
      KIND_DATA
   } kind_type;

   typedef struct packed {
      op_type      op;
      kind_type    kind;
      logic        key;
      logic [31:0] stamp;
      logic [23:0] bytes;
      logic [31:0] now;
   } req_item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } back_state_type;

endpackage

`default_nettype wire

### design/msm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_front
// Request intake: unpacks the request and classifies operation and media kind.
// ----------------------------------------------------------------------------
module msm_front
   import msm_pkg::*;
(
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       push_valid,
   input  wire logic                  push_ready,
   output req_item_type               push_item
);

   op_type   op;
   kind_type kind;

   always_comb begin
      case (req_tuser[1:0])
         FUNC_MEDIA: op = OP_MEDIA;
         FUNC_START: op = OP_START;
         FUNC_STOP:  op = OP_STOP;
         default:    op = OP_NONE;
      endcase
      case (req_tuser[3:2])
         MEDIA_VIDEO: kind = KIND_VIDEO;
         MEDIA_AUDIO: kind = KIND_AUDIO;
         default:     kind = KIND_DATA;
      endcase
   end

   assign req_tready      = push_ready;
   assign push_valid      = req_tvalid;
   assign push_item.op    = op;
   assign push_item.kind  = kind;
   assign push_item.key   = req_tuser[4] & (kind == KIND_VIDEO);
   assign push_item.stamp = req_tdata[31:0];
   assign push_item.bytes = req_tdata[55:32];
   assign push_item.now   = req_tdata[87:56];

endmodule

`default_nettype wire

### design/msm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_queue
// Short request queue between intake and execution.
// ----------------------------------------------------------------------------
module msm_queue
   import msm_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire req_item_type push_item,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output req_item_type      pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   req_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

### design/msm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_div
// Restoring divider, one quotient bit per cycle, for the bitrate update.
// ----------------------------------------------------------------------------
module msm_div
   import msm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [31:0]           divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [31:0]           rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [31:0]           dsr_ff, dsr_in;
   logic [32:0]           shifted;
   logic                  fits;

   assign shifted  = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits     = (shifted >= {1'b0, dsr_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 32'(shifted - {1'b0, dsr_ff}) : shifted[31:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
   end

endmodule

`default_nettype wire

### design/msm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_back
// Execution: session state, counters, gap check, bitrate window and the
// result register.
// ----------------------------------------------------------------------------
module msm_back
   import msm_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire req_item_type          pop_item,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   back_state_type state_ff, state_in;
   req_item_type   item_ff, item_in;

   logic [31:0] thr_ff, thr_in;
   logic [31:0] win_ff, win_in;
   logic        active_ff, active_in;
   logic        seen_video_ff, seen_video_in;
   logic        seen_audio_ff, seen_audio_in;
   logic [31:0] last_video_ff, last_video_in;
   logic [31:0] last_audio_ff, last_audio_in;
   logic [47:0] bytes_total_ff, bytes_total_in;
   logic [31:0] video_cnt_ff, video_cnt_in;
   logic [31:0] audio_cnt_ff, audio_cnt_in;
   logic [31:0] key_cnt_ff, key_cnt_in;
   logic [31:0] gap_cnt_ff, gap_cnt_in;
   logic [63:0] bitrate_ff, bitrate_in;
   logic [31:0] duration_ff, duration_in;
   logic [31:0] start_time_ff, start_time_in;
   logic [31:0] win_start_ff, win_start_in;
   logic [39:0] win_bytes_ff, win_bytes_in;
   logic        gap_found_ff, gap_found_in;
   logic [31:0] gap_size_ff, gap_size_in;
   logic [31:0] gap_prev_ff, gap_prev_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   logic [48:0]           bytes_sum;
   logic [47:0]           bytes_sat;
   logic [40:0]           win_sum;
   logic [39:0]           win_sat;
   logic                  is_av;
   logic                  had_first;
   logic [31:0]           prev_stamp;
   logic [31:0]           stamp_diff;
   logic                  wrap_case;
   logic                  gap_hit;
   logic [31:0]           elapsed;
   logic                  window_due;
   logic [DIVIDEND_W-1:0] win_ext;
   logic [DIVIDEND_W-1:0] dividend;
   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] quotient;

   // datapath for one media request
   always_comb begin
      bytes_sum  = {1'b0, bytes_total_ff} + 49'(item_ff.bytes);
      bytes_sat  = bytes_sum[48] ? BYTES_MAX : bytes_sum[47:0];
      win_sum    = {1'b0, win_bytes_ff} + 41'(item_ff.bytes);
      win_sat    = win_sum[40] ? WINDOW_BYTES_MAX : win_sum[39:0];
      is_av      = (item_ff.kind == KIND_VIDEO) || (item_ff.kind == KIND_AUDIO);
      had_first  = (item_ff.kind == KIND_VIDEO) ? seen_video_ff : seen_audio_ff;
      prev_stamp = (item_ff.kind == KIND_VIDEO) ? last_video_ff : last_audio_ff;
      stamp_diff = item_ff.stamp - prev_stamp;
      wrap_case  = (prev_stamp > WRAP_HALF) && (item_ff.stamp < WRAP_LOW);
      gap_hit    = is_av && had_first && !wrap_case && (item_ff.stamp > prev_stamp)
                   && (stamp_diff > thr_ff);
      elapsed    = item_ff.now - win_start_ff;
      window_due = (elapsed >= win_ff);
      win_ext    = DIVIDEND_W'(win_sat);
      // times 8000 as 8192 - 128 - 64
      dividend   = (win_ext << 13) - (win_ext << 7) - (win_ext << 6);
   end

   msm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (elapsed),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      thr_in         = thr_ff;
      win_in         = win_ff;
      active_in      = active_ff;
      seen_video_in  = seen_video_ff;
      seen_audio_in  = seen_audio_ff;
      last_video_in  = last_video_ff;
      last_audio_in  = last_audio_ff;
      bytes_total_in = bytes_total_ff;
      video_cnt_in   = video_cnt_ff;
      audio_cnt_in   = audio_cnt_ff;
      key_cnt_in     = key_cnt_ff;
      gap_cnt_in     = gap_cnt_ff;
      bitrate_in     = bitrate_ff;
      duration_in    = duration_ff;
      start_time_in  = start_time_ff;
      win_start_in   = win_start_ff;
      win_bytes_in   = win_bytes_ff;
      gap_found_in   = gap_found_ff;
      gap_size_in    = gap_size_ff;
      gap_prev_in    = gap_prev_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      pop_ready      = 1'b0;
      div_start      = 1'b0;

      if (csr_we) begin
         case (csr_addr)
            CSR_GAP_THRESHOLD:  thr_in = csr_wdata;
            CSR_BITRATE_WINDOW: win_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid && (!rsp_valid_ff || rsp_tready)) begin
               pop_ready = 1'b1;
               item_in   = pop_item;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            gap_found_in = 1'b0;
            gap_size_in  = '0;
            gap_prev_in  = '0;
            state_in     = ST_DONE;
            case (item_ff.op)
               OP_START: begin
                  if (!active_ff) begin
                     active_in      = 1'b1;
                     seen_video_in  = 1'b0;
                     seen_audio_in  = 1'b0;
                     last_video_in  = '0;
                     last_audio_in  = '0;
                     bytes_total_in = '0;
                     video_cnt_in   = '0;
                     audio_cnt_in   = '0;
                     key_cnt_in     = '0;
                     gap_cnt_in     = '0;
                     bitrate_in     = '0;
                     duration_in    = '0;
                     win_bytes_in   = '0;
                     start_time_in  = item_ff.now;
                     win_start_in   = item_ff.now;
                  end
               end
               OP_STOP: begin
                  active_in = 1'b0;
               end
               OP_MEDIA: begin
                  if (active_ff) begin
                     bytes_total_in = bytes_sat;
                     if (item_ff.kind == KIND_VIDEO) begin
                        if (video_cnt_ff != COUNT_MAX) video_cnt_in = video_cnt_ff + 1'b1;
                        if (item_ff.key && (key_cnt_ff != COUNT_MAX)) begin
                           key_cnt_in = key_cnt_ff + 1'b1;
                        end
                        seen_video_in = 1'b1;
                        last_video_in = item_ff.stamp;
                     end
                     if (item_ff.kind == KIND_AUDIO) begin
                        if (audio_cnt_ff != COUNT_MAX) audio_cnt_in = audio_cnt_ff + 1'b1;
                        seen_audio_in = 1'b1;
                        last_audio_in = item_ff.stamp;
                     end
                     if (gap_hit) begin
                        gap_found_in = 1'b1;
                        gap_size_in  = stamp_diff;
                        gap_prev_in  = prev_stamp;
                        if (gap_cnt_ff != COUNT_MAX) gap_cnt_in = gap_cnt_ff + 1'b1;
                     end
                     win_bytes_in = win_sat;
                     if (window_due) begin
                        win_bytes_in = '0;
                        win_start_in = item_ff.now;
                        if (elapsed != '0) begin
                           div_start = 1'b1;
                           state_in  = ST_DIV;
                        end
                     end
                     duration_in = item_ff.now - start_time_ff;
                  end
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               bitrate_in = 64'(quotient);
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_user_in  = {gap_found_ff, active_ff};
            rsp_data_in  = {duration_ff, bitrate_ff, gap_cnt_ff, key_cnt_ff,
                            audio_cnt_ff, video_cnt_ff, bytes_total_ff,
                            gap_prev_ff, gap_size_ff};
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         thr_ff         <= GAP_THRESHOLD_RST;
         win_ff         <= BITRATE_WINDOW_RST;
         active_ff      <= 1'b0;
         seen_video_ff  <= 1'b0;
         seen_audio_ff  <= 1'b0;
         last_video_ff  <= '0;
         last_audio_ff  <= '0;
         bytes_total_ff <= '0;
         video_cnt_ff   <= '0;
         audio_cnt_ff   <= '0;
         key_cnt_ff     <= '0;
         gap_cnt_ff     <= '0;
         bitrate_ff     <= '0;
         duration_ff    <= '0;
         start_time_ff  <= '0;
         win_start_ff   <= '0;
         win_bytes_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         thr_ff         <= thr_in;
         win_ff         <= win_in;
         active_ff      <= active_in;
         seen_video_ff  <= seen_video_in;
         seen_audio_ff  <= seen_audio_in;
         last_video_ff  <= last_video_in;
         last_audio_ff  <= last_audio_in;
         bytes_total_ff <= bytes_total_in;
         video_cnt_ff   <= video_cnt_in;
         audio_cnt_ff   <= audio_cnt_in;
         key_cnt_ff     <= key_cnt_in;
         gap_cnt_ff     <= gap_cnt_in;
         bitrate_ff     <= bitrate_in;
         duration_ff    <= duration_in;
         start_time_ff  <= start_time_in;
         win_start_ff   <= win_start_in;
         win_bytes_ff   <= win_bytes_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      gap_found_ff <= gap_found_in;
      gap_size_ff  <= gap_size_in;
      gap_prev_ff  <= gap_prev_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### design/media_stream_statistics_monitor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// media_stream_statistics_monitor_unit
// Media session statistics: byte and frame counters, per-kind timestamp gap
// detection and a windowed bitrate estimate.
// ----------------------------------------------------------------------------
// Each request (start, stop or media message) yields exactly one response with
// the current statistics. Requests enter a short queue and are executed one at
// a time: the execution side takes a request, executes it and then responds;
// when it closes a bitrate window with nonzero elapsed time, it waits between
// execute and respond on the 53-step one-bit-per-cycle divider that computes
// bytes*8000/elapsed. While a response waits, requests still enter the queue
// until it is full; the next one is taken when the response leaves. The user
// must write the configuration registers (index 0 gap threshold, index 1
// bitrate window) only while no request is in flight; the block itself does
// not enforce this.
module media_stream_statistics_monitor_unit
   import msm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // media_timestamp, payload_bytes, now_ms
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // func, media_kind, is_keyframe
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // gap_size_ms, gap_previous_stamp, bytes_total, video_count, audio_count,
   // keyframe_count, gap_total, bitrate_bps, session_duration_ms
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // session_active, gap_found
   output logic [RSP_USER_W-1:0]      rsp_tuser
);

   logic         push_valid, push_ready;
   req_item_type push_item;
   logic         pop_valid, pop_ready;
   req_item_type pop_item;

   msm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   msm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   msm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

### design/msm_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_checker
// Port-level checks on the response channel of the statistics monitor.
// ----------------------------------------------------------------------------
module msm_checker
   import msm_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [RSP_USER_W-1:0] rsp_tuser
);

   a_no_valid_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_gap_needs_session: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && (rsp_tdata[31:0] != 32'd0))
      else $error("gap reported outside a session or with zero size");

   a_no_gap_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> (rsp_tdata[31:0] == 32'd0)
                                      && (rsp_tdata[63:32] == 32'd0))
      else $error("gap fields set without a gap");

endmodule

bind media_stream_statistics_monitor_unit msm_checker u_msm_checker (.*);

`default_nettype wire
